FILE: src/kst_pkg.sv
// Shared types for the keyed slot table: request and response items
// and the outcome codes. No dependencies.
package kst_pkg;

  localparam int INDEX_W = 4;
  localparam int TOTAL_W = 5;

  typedef struct packed {
    logic signed [31:0] owner_key;
    logic signed [31:0] payload_value;
    logic signed [31:0] current_time;
  } kst_req_t;

  typedef enum logic [1:0] {
    OUTCOME_EXISTING = 2'd0,
    OUTCOME_FREE     = 2'd1,
    OUTCOME_EVICTED  = 2'd2,
    OUTCOME_REFUSED  = 2'd3
  } kst_outcome_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    kst_outcome_t       outcome;
    logic [TOTAL_W-1:0] used_total;
  } kst_rsp_t;

endpackage

FILE: src/kst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependencies.
module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/keyed_slot_table_with_eviction_top.sv
// Keyed slot table with eviction: top level. Uses kst_pkg and kst_ram.
// Each request is scanned over all slots before the next is taken: the table
// RAM read port scans one slot per cycle through a single key/time compare
// unit, and req_stall stays high until the response is registered, which
// waits for the previous response to be taken.
// Reset (synchronous, active high) clears all used marks and the used count;
// slot contents stay undefined until written. No clearing pass.
module keyed_slot_table_with_eviction_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  kst_pkg::kst_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output kst_pkg::kst_rsp_t rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    LAST,
    FINISH
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_used;
  logic              used [SLOT_COUNT];
  logic [CNT_W-1:0]  used_count;
  kst_pkg::kst_req_t req_q;
  kst_pkg::kst_req_t entry;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              old_found;
  logic [IDX_W-1:0]  old_idx;
  kst_pkg::kst_rsp_t rsp_q;

  logic                  key_match;
  logic                  older;
  logic                  place;
  logic                  finish_go;
  logic [IDX_W-1:0]      target;
  kst_pkg::kst_outcome_t outcome;
  logic [CNT_W-1:0]      used_count_next;

  kst_ram #(
    .WIDTH ($bits(kst_pkg::kst_req_t)),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (finish_go && place),
    .waddr (target),
    .wdata (req_q),
    .raddr (idx),
    .rdata (entry)
  );

  // Shared compare unit: one slot per cycle, only used slots count.
  assign key_match = rd_used && (entry.owner_key == req_q.owner_key);
  assign older     = rd_used &&
                     ($signed(req_q.current_time) > $signed(entry.current_time));

  always_comb begin
    place = !hit_found && (free_found || old_found);
    if (hit_found) begin
      target  = hit_idx;
      outcome = kst_pkg::OUTCOME_EXISTING;
    end else if (free_found) begin
      target  = free_idx;
      outcome = kst_pkg::OUTCOME_FREE;
    end else if (old_found) begin
      target  = old_idx;
      outcome = kst_pkg::OUTCOME_EVICTED;
    end else begin
      target  = '0;
      outcome = kst_pkg::OUTCOME_REFUSED;
    end
    used_count_next = used_count + CNT_W'(!hit_found && free_found);
  end

  assign finish_go = (state == FINISH) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != IDLE);
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rsp_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      used_count <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        used[i] <= 1'b0;
      end
    end else begin
      if (finish_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // Align the used mark and index with the registered RAM read.
      rd_valid <= (state == SCAN);
      rd_idx   <= idx;
      rd_used  <= used[idx];

      if (rd_valid) begin
        if (key_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
        end
        if (!rd_used && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        // Keep the highest-indexed older slot.
        if (older) begin
          old_found <= 1'b1;
          old_idx   <= rd_idx;
        end
      end

      unique case (state)
        IDLE: begin
          if (req_valid) begin
            req_q      <= req;
            idx        <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            old_found  <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          idx <= idx + IDX_W'(1);
          if (idx == LAST_IDX) begin
            state <= LAST;
          end
        end
        LAST: begin
          state <= FINISH;
        end
        FINISH: begin
          if (finish_go) begin
            rsp_q.slot_index <= kst_pkg::INDEX_W'(target);
            rsp_q.outcome    <= outcome;
            rsp_q.used_total <= kst_pkg::TOTAL_W'(used_count_next);
            used_count       <= used_count_next;
            if (place) begin
              used[target] <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/keyed_slot_table_with_eviction_top_tb.sv
// Testbench for the keyed slot table: directed and random requests, with an
// in-bench copy of the table that predicts every response.
// Depends on kst_pkg and keyed_slot_table_with_eviction_top.
module keyed_slot_table_with_eviction_top_tb;

  localparam int SLOTS          = 16;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 3 * (SLOTS + 3);
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  kst_pkg::kst_req_t req       = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  kst_pkg::kst_rsp_t rsp;

  kst_pkg::kst_req_t pending_req_q[$];
  kst_pkg::kst_rsp_t expected_rsp_q[$];

  // Table as the block should hold it
  bit                 tbl_used    [SLOTS] = '{default: 1'b0};
  logic signed [31:0] tbl_owner   [SLOTS];
  logic signed [31:0] tbl_stamp   [SLOTS];
  logic signed [31:0] tbl_payload [SLOTS];

  logic signed [31:0] key_pool [POOL_SIZE];

  int total_items = 0;
  int accepted_n  = 0;
  int mismatch_n  = 0;
  int idle_cycles = 0;
  int req_idle_pct;
  int rsp_stall_pct;

  keyed_slot_table_with_eviction_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Idle phases follow progress through the item list
  always_comb begin
    case ((total_items == 0) ? 0 : accepted_n * 4 / total_items)
      1:       begin req_idle_pct = 55; rsp_stall_pct = 0;  end
      2:       begin req_idle_pct = 0;  rsp_stall_pct = 55; end
      3:       begin req_idle_pct = 38; rsp_stall_pct = 38; end
      default: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
    endcase
  end

  // Apply one request to the table and return the response it should give
  function automatic kst_pkg::kst_rsp_t place_request(kst_pkg::kst_req_t r);
    int                i;
    int                hit;
    int                target;
    int                used_n;
    kst_pkg::kst_rsp_t res;
    hit    = -1;
    target = -1;
    used_n = 0;
    res    = '0;
    for (i = 0; i < SLOTS; i++)
      if (hit < 0 && tbl_used[i] && tbl_owner[i] == r.owner_key) hit = i;
    if (hit >= 0) begin
      target      = hit;
      res.outcome = kst_pkg::OUTCOME_EXISTING;
    end else begin
      for (i = 0; i < SLOTS; i++)
        if (target < 0 && !tbl_used[i]) target = i;
      if (target >= 0) begin
        res.outcome = kst_pkg::OUTCOME_FREE;
      end else begin
        // last strictly older slot wins; equal stamps are not older
        for (i = 0; i < SLOTS; i++)
          if (r.current_time > tbl_stamp[i]) target = i;
        res.outcome = (target >= 0) ? kst_pkg::OUTCOME_EVICTED
                                    : kst_pkg::OUTCOME_REFUSED;
      end
      if (target >= 0) begin
        tbl_used[target]    = 1'b1;
        tbl_owner[target]   = r.owner_key;
        tbl_stamp[target]   = r.current_time;
        tbl_payload[target] = r.payload_value;
      end
    end
    for (i = 0; i < SLOTS; i++)
      if (tbl_used[i]) used_n++;
    res.slot_index = (target >= 0) ? target[kst_pkg::INDEX_W-1:0] : '0;
    res.used_total = used_n[kst_pkg::TOTAL_W-1:0];
    return res;
  endfunction

  task automatic queue_req(input logic signed [31:0] key, input logic signed [31:0] data,
                           input logic signed [31:0] stamp);
    kst_pkg::kst_req_t item;
    item.owner_key     = key;
    item.payload_value = data;
    item.current_time  = stamp;
    pending_req_q = {pending_req_q, item};
  endtask

  // Request driver: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin : drive
    logic hold;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      hold = req_valid && req_stall;
      if (req_valid && !req_stall) begin
        expected_rsp_q = {expected_rsp_q, place_request(req)};
        accepted_n <= accepted_n + 1;
      end
      if (!hold) begin
        if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
          req_valid <= 1'b1;
          req       <= pending_req_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver stall
  always @(posedge clk) begin : check
    kst_pkg::kst_rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          if (mismatch_n < 10)
            $display("unexpected response: index %0d outcome %0d used %0d",
                     rsp.slot_index, rsp.outcome, rsp.used_total);
          mismatch_n++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.slot_index !== want.slot_index || rsp.outcome !== want.outcome ||
              rsp.used_total !== want.used_total) begin
            if (mismatch_n < 10)
              $display("mismatch: expected index %0d outcome %0d used %0d, got %0d %0d %0d",
                       want.slot_index, want.outcome, want.used_total,
                       rsp.slot_index, rsp.outcome, rsp.used_total);
            mismatch_n++;
          end
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int                 n;
    int                 i;
    int                 roll;
    logic signed [31:0] now_t;
    kst_pkg::kst_req_t  item;

    key_pool[0] = S32_MIN;
    key_pool[1] = S32_MAX;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Directed: fill, hit, refuse at the oldest time, equal stamps, evictions
    queue_req(key_pool[0], S32_MAX, S32_MIN);
    queue_req(key_pool[0], S32_MIN, 32'sd5);
    for (i = 1; i < SLOTS; i++) queue_req(key_pool[i], $urandom, 32'sd100);
    queue_req($urandom, 32'sd0, S32_MIN);
    queue_req($urandom, -32'sd1, 32'sd100);
    queue_req($urandom, $urandom, S32_MAX);
    queue_req(key_pool[2], $urandom, 32'sd7);
    queue_req($urandom, $urandom, 32'sd101);
    queue_req($urandom, $urandom, 32'sd100);

    // Random: keys mostly from a pool so hits and re-entries happen, time
    // mostly advancing with back-offs, jumps and the odd wild value
    now_t = 32'sd200;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      item.owner_key     = ($urandom_range(0, 99) < 70) ?
                           key_pool[$urandom_range(0, POOL_SIZE-1)] : $urandom;
      item.payload_value = $urandom;
      roll = $urandom_range(0, 999);
      if (roll < 15) begin
        item.current_time = $urandom;
      end else if (roll < 20) begin
        item.current_time = S32_MIN;
      end else if (roll < 25) begin
        item.current_time = S32_MAX;
      end else if (roll < 110) begin
        item.current_time = now_t - $urandom_range(0, 40);
      end else begin
        if (roll >= 980 && now_t < 32'sh6000_0000)
          now_t = now_t + $urandom_range(0, 1 << 26);
        else
          now_t = now_t + $urandom_range(0, 3);
        item.current_time = now_t;
      end
      pending_req_q = {pending_req_q, item};
    end
    total_items = pending_req_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_n == 0 && expected_rsp_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
